[hdl/tmr_pkg.sv]
// shared types, codes and field widths of the timer bank
`timescale 1ns / 1ps
`default_nettype none

package tmr_pkg;

  localparam int unsigned LEN_W  = 32;
  localparam int unsigned PID_W  = 16;
  localparam int unsigned SLOT_W = 3;
  localparam int unsigned REQ_W  = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_CREATE  = 3'd0,
    REQ_DELETE  = 3'd1,
    REQ_START   = 3'd2,
    REQ_STOP    = 3'd3,
    REQ_SET_LEN = 3'd4,
    REQ_QUERY   = 3'd5,
    REQ_TICK    = 3'd6
  } req_e;

  typedef enum logic [1:0] {
    KIND_REPLY     = 2'd0,
    KIND_EXPIRY    = 2'd1,
    KIND_TICK_DONE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_OK          = 2'd0,
    ERR_RANGE       = 2'd1,
    ERR_NOT_CREATED = 2'd2,
    ERR_FULL        = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_EXEC,
    ST_TICK,
    ST_TUPD,
    ST_MSG,
    ST_TEND
  } state_e;

  typedef struct packed {
    kind_e              kind;
    logic [SLOT_W-1:0]  slot;
    logic [PID_W-1:0]   dest_pid;
    logic [PID_W-1:0]   sender_pid;
    err_e               error;
    logic               is_active;
    logic [LEN_W-1:0]   elapsed;
    logic               last;
  } res_t;

  function automatic res_t make_reply(logic [SLOT_W-1:0] slot, err_e err);
    res_t r;
    r       = '0;
    r.kind  = KIND_REPLY;
    r.slot  = slot;
    r.error = err;
    r.last  = 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/tmr_mem.sv]
// single-port-write, single-port-read timer record memory, registered read
`timescale 1ns / 1ps
`default_nettype none

module tmr_mem #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hdl/multi_timer_bank.sv]
// timer bank top level: command sequencer, slot flags and result register
`timescale 1ns / 1ps
`default_nettype none

// One command is taken when start_i is high and busy_o is low. Delete, stop,
// unknown requests and every request that fails its checks answer with one
// result in the cycle after acceptance and leave busy_o low. Start, set length
// and query read the slot record from memory and answer from the execute state
// through the result register. Create scans the used flags one slot per cycle
// and answers for the first free slot, or with a full error after the last
// slot. A tick walks the slots in order: an idle slot is passed over, an active
// one has its record read, then updated and written back, and an expiring one
// then gives one expiry result per nonzero destination; the tick-finished
// result ends the walk, shown from the end state when the last slot is active.
// The single read and write ports of the record memory bound the walk. Each
// result is shown for exactly one cycle with strobe_o high and cannot be held
// off, and the result marked last_o comes out as busy_o drops.
module multi_timer_bank #(
  parameter int unsigned NUM_TIMERS = 8,
  parameter int unsigned DEST_SLOTS = 2
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire logic [tmr_pkg::REQ_W-1:0]   req_type_i,
  input  wire logic [tmr_pkg::SLOT_W-1:0]  timer_id_i,
  input  wire logic [tmr_pkg::LEN_W-1:0]   length_i,
  input  wire logic                        periodic_i,
  input  wire logic [tmr_pkg::PID_W-1:0]   source_pid_i,
  input  wire logic [tmr_pkg::PID_W-1:0]   dest_pid_first_i,
  input  wire logic [tmr_pkg::PID_W-1:0]   dest_pid_second_i,
  output logic                             strobe_o,
  output logic [1:0]                       kind_o,
  output logic [tmr_pkg::SLOT_W-1:0]       slot_o,
  output logic [tmr_pkg::PID_W-1:0]        dest_pid_o,
  output logic [tmr_pkg::PID_W-1:0]        sender_pid_o,
  output logic [1:0]                       error_o,
  output logic                             is_active_o,
  output logic [tmr_pkg::LEN_W-1:0]        elapsed_o,
  output logic                             last_o
);

  localparam int unsigned IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned XW = (IW > tmr_pkg::SLOT_W) ? IW : tmr_pkg::SLOT_W;
  localparam int unsigned DW = (DEST_SLOTS > 1) ? $clog2(DEST_SLOTS) : 1;

  typedef struct packed {
    logic                                        periodic;
    logic [tmr_pkg::LEN_W-1:0]                   length;
    logic [tmr_pkg::LEN_W-1:0]                   count;
    logic [tmr_pkg::PID_W-1:0]                   source;
    logic [DEST_SLOTS-1:0][tmr_pkg::PID_W-1:0]   dests;
  } row_t;

  localparam int unsigned ROW_W = $bits(row_t);

  tmr_pkg::state_e state_q, state_d;

  logic [NUM_TIMERS-1:0] used_q, used_d;
  logic [NUM_TIMERS-1:0] active_q, active_d;
  logic [IW-1:0]         scan_q, scan_d;
  logic [DW-1:0]         dsel_q, dsel_d;
  logic [tmr_pkg::REQ_W-1:0] req_q;
  logic                  strobe_q, strobe_d;

  // latched command payload
  logic [tmr_pkg::SLOT_W-1:0] id_q;
  logic [tmr_pkg::LEN_W-1:0]  len_q;
  logic                       per_q;
  logic [tmr_pkg::PID_W-1:0]  src_q;
  logic [tmr_pkg::PID_W-1:0]  dst0_q;
  logic [tmr_pkg::PID_W-1:0]  dst1_q;

  tmr_pkg::res_t res_q, res_d;
  row_t          row_q, row_d;

  // memory port
  logic             mem_we;
  logic [IW-1:0]    mem_waddr;
  row_t             mem_wrow;
  logic             mem_re;
  logic [IW-1:0]    mem_raddr;
  logic [ROW_W-1:0] mem_rdata;
  row_t             row_rd;

  logic                       accept;
  logic                       in_oor;
  logic [XW-1:0]              in_id_x;
  logic [IW-1:0]              in_idx;
  logic                       in_used;
  logic [XW-1:0]              idq_x;
  logic [IW-1:0]              idq_idx;
  logic [XW-1:0]              scan_x;
  logic [tmr_pkg::SLOT_W-1:0] scan_slot;
  logic                       scan_last;
  logic                       scan_act;
  logic                       d_last;
  logic [tmr_pkg::LEN_W-1:0]  cnt_inc;
  logic                       expired;
  logic [tmr_pkg::PID_W-1:0]  cur_dest;
  row_t                       new_row;

  assign accept    = start_i && (state_q == tmr_pkg::ST_IDLE);
  assign busy_o    = (state_q != tmr_pkg::ST_IDLE);

  assign in_oor    = (32'(timer_id_i) >= NUM_TIMERS);
  assign in_id_x   = XW'(timer_id_i);
  assign in_idx    = in_id_x[IW-1:0];
  assign in_used   = used_q[in_idx];
  assign idq_x     = XW'(id_q);
  assign idq_idx   = idq_x[IW-1:0];
  assign scan_x    = XW'(scan_q);
  assign scan_slot = scan_x[tmr_pkg::SLOT_W-1:0];
  assign scan_last = (scan_q == IW'(NUM_TIMERS - 1));
  assign scan_act  = used_q[scan_q] && active_q[scan_q];
  assign d_last    = (dsel_q == DW'(DEST_SLOTS - 1));

  assign row_rd    = row_t'(mem_rdata);
  assign cnt_inc   = row_rd.count + 32'd1;
  // count reached or passed the length
  assign expired   = !(cnt_inc < row_rd.length);
  assign cur_dest  = row_q.dests[dsel_q];

  always_comb begin
    new_row          = '0;
    new_row.periodic = per_q;
    new_row.length   = len_q;
    new_row.source   = src_q;
    for (int d = 0; d < DEST_SLOTS; d++) begin
      if (d == 0) begin
        new_row.dests[d] = dst0_q;
      end else if (d == 1) begin
        new_row.dests[d] = dst1_q;
      end else begin
        new_row.dests[d] = '0;
      end
    end
  end

  tmr_mem #(
    .DEPTH(NUM_TIMERS),
    .WIDTH(ROW_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (ROW_W'(mem_wrow)),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tmr_pkg::ST_IDLE: begin
        if (accept) begin
          case (req_type_i)
            tmr_pkg::REQ_CREATE: state_d = tmr_pkg::ST_FIND;
            tmr_pkg::REQ_TICK:   state_d = tmr_pkg::ST_TICK;
            tmr_pkg::REQ_START, tmr_pkg::REQ_SET_LEN, tmr_pkg::REQ_QUERY: begin
              if (!in_oor && in_used) begin
                state_d = tmr_pkg::ST_EXEC;
              end
            end
            default: state_d = tmr_pkg::ST_IDLE;
          endcase
        end
      end
      tmr_pkg::ST_FIND: begin
        if (!used_q[scan_q] || scan_last) begin
          state_d = tmr_pkg::ST_IDLE;
        end
      end
      tmr_pkg::ST_EXEC: state_d = tmr_pkg::ST_IDLE;
      tmr_pkg::ST_TICK: begin
        if (scan_act) begin
          state_d = tmr_pkg::ST_TUPD;
        end else if (scan_last) begin
          state_d = tmr_pkg::ST_IDLE;
        end
      end
      tmr_pkg::ST_TUPD: begin
        if (expired) begin
          state_d = tmr_pkg::ST_MSG;
        end else if (scan_last) begin
          state_d = tmr_pkg::ST_TEND;
        end else begin
          state_d = tmr_pkg::ST_TICK;
        end
      end
      tmr_pkg::ST_MSG: begin
        if (d_last) begin
          state_d = scan_last ? tmr_pkg::ST_TEND : tmr_pkg::ST_TICK;
        end
      end
      tmr_pkg::ST_TEND: state_d = tmr_pkg::ST_IDLE;
      default:          state_d = tmr_pkg::ST_IDLE;
    endcase
  end

  // datapath, flag updates, memory accesses and results
  always_comb begin
    used_d    = used_q;
    active_d  = active_q;
    scan_d    = scan_q;
    dsel_d    = dsel_q;
    row_d     = row_q;
    res_d     = '0;
    strobe_d  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = scan_q;
    mem_wrow  = row_rd;
    mem_re    = 1'b0;
    mem_raddr = scan_q;

    case (state_q)
      tmr_pkg::ST_IDLE: begin
        if (accept) begin
          case (req_type_i)
            tmr_pkg::REQ_CREATE, tmr_pkg::REQ_TICK: begin
              scan_d = '0;
            end
            tmr_pkg::REQ_DELETE, tmr_pkg::REQ_START, tmr_pkg::REQ_STOP,
            tmr_pkg::REQ_SET_LEN, tmr_pkg::REQ_QUERY: begin
              if (in_oor) begin
                strobe_d = 1'b1;
                res_d    = tmr_pkg::make_reply(timer_id_i, tmr_pkg::ERR_RANGE);
              end else if (req_type_i == tmr_pkg::REQ_DELETE) begin
                used_d[in_idx]   = 1'b0;
                active_d[in_idx] = 1'b0;
                strobe_d         = 1'b1;
                res_d            = tmr_pkg::make_reply(timer_id_i, tmr_pkg::ERR_OK);
              end else if (!in_used) begin
                strobe_d = 1'b1;
                res_d    = tmr_pkg::make_reply(timer_id_i, tmr_pkg::ERR_NOT_CREATED);
              end else if (req_type_i == tmr_pkg::REQ_STOP) begin
                active_d[in_idx] = 1'b0;
                strobe_d         = 1'b1;
                res_d            = tmr_pkg::make_reply(timer_id_i, tmr_pkg::ERR_OK);
              end else begin
                mem_re    = 1'b1;
                mem_raddr = in_idx;
              end
            end
            default: begin
              strobe_d = 1'b1;
              res_d    = tmr_pkg::make_reply(timer_id_i, tmr_pkg::ERR_OK);
            end
          endcase
        end
      end

      tmr_pkg::ST_FIND: begin
        if (!used_q[scan_q]) begin
          mem_we           = 1'b1;
          mem_waddr        = scan_q;
          mem_wrow         = new_row;
          used_d[scan_q]   = 1'b1;
          active_d[scan_q] = 1'b0;
          strobe_d         = 1'b1;
          res_d            = tmr_pkg::make_reply(scan_slot, tmr_pkg::ERR_OK);
        end else if (scan_last) begin
          strobe_d = 1'b1;
          res_d    = tmr_pkg::make_reply('0, tmr_pkg::ERR_FULL);
        end else begin
          scan_d = scan_q + IW'(1);
        end
      end

      tmr_pkg::ST_EXEC: begin
        strobe_d  = 1'b1;
        res_d     = tmr_pkg::make_reply(id_q, tmr_pkg::ERR_OK);
        mem_waddr = idq_idx;
        mem_wrow  = row_rd;
        case (req_q)
          tmr_pkg::REQ_START: begin
            mem_we            = 1'b1;
            mem_wrow.count    = '0;
            active_d[idq_idx] = 1'b1;
          end
          tmr_pkg::REQ_SET_LEN: begin
            mem_we          = 1'b1;
            mem_wrow.length = len_q;
            mem_wrow.count  = '0;
          end
          tmr_pkg::REQ_QUERY: begin
            res_d.is_active = active_q[idq_idx];
            res_d.elapsed   = row_rd.count;
          end
          default: begin
            mem_we = 1'b0;
          end
        endcase
      end

      tmr_pkg::ST_TICK: begin
        if (scan_act) begin
          mem_re    = 1'b1;
          mem_raddr = scan_q;
        end else if (scan_last) begin
          strobe_d   = 1'b1;
          res_d.kind = tmr_pkg::KIND_TICK_DONE;
          res_d.last = 1'b1;
        end else begin
          scan_d = scan_q + IW'(1);
        end
      end

      tmr_pkg::ST_TUPD: begin
        mem_we         = 1'b1;
        mem_waddr      = scan_q;
        mem_wrow       = row_rd;
        mem_wrow.count = expired ? '0 : cnt_inc;
        if (expired) begin
          row_d  = row_rd;
          dsel_d = '0;
          if (!row_rd.periodic) begin
            active_d[scan_q] = 1'b0;
          end
        end else if (!scan_last) begin
          scan_d = scan_q + IW'(1);
        end
      end

      tmr_pkg::ST_MSG: begin
        // one beat per nonzero destination
        if (cur_dest != '0) begin
          strobe_d         = 1'b1;
          res_d.kind       = tmr_pkg::KIND_EXPIRY;
          res_d.slot       = scan_slot;
          res_d.dest_pid   = cur_dest;
          res_d.sender_pid = row_q.source;
        end
        if (d_last) begin
          if (!scan_last) begin
            scan_d = scan_q + IW'(1);
          end
        end else begin
          dsel_d = dsel_q + DW'(1);
        end
      end

      tmr_pkg::ST_TEND: begin
        strobe_d   = 1'b1;
        res_d.kind = tmr_pkg::KIND_TICK_DONE;
        res_d.last = 1'b1;
      end

      default: begin
        strobe_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= tmr_pkg::ST_IDLE;
      used_q   <= '0;
      active_q <= '0;
      scan_q   <= '0;
      dsel_q   <= '0;
      req_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      used_q   <= used_d;
      active_q <= active_d;
      scan_q   <= scan_d;
      dsel_q   <= dsel_d;
      strobe_q <= strobe_d;
      if (accept) begin
        req_q <= req_type_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    row_q <= row_d;
    if (accept) begin
      id_q   <= timer_id_i;
      len_q  <= length_i;
      per_q  <= periodic_i;
      src_q  <= source_pid_i;
      dst0_q <= dest_pid_first_i;
      dst1_q <= dest_pid_second_i;
    end
  end

  assign strobe_o     = strobe_q;
  assign kind_o       = res_q.kind;
  assign slot_o       = res_q.slot;
  assign dest_pid_o   = res_q.dest_pid;
  assign sender_pid_o = res_q.sender_pid;
  assign error_o      = res_q.error;
  assign is_active_o  = res_q.is_active;
  assign elapsed_o    = res_q.elapsed;
  assign last_o       = res_q.last;

  // the final beat of a command leaves together with the return to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && last_o) |-> !busy_o)
    else $error("last result while sequencer busy");

  a_fell_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> (strobe_o && last_o))
    else $error("sequencer went idle without a last result");

  a_active_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q & ~used_q) == '0)
    else $error("free slot marked active");

  a_msg_dest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && kind_o == tmr_pkg::KIND_EXPIRY) |-> (dest_pid_o != '0 && !last_o))
    else $error("expiry message with empty destination or last set");

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// self-checking testbench of the timer bank: directed commands, then random traffic
`timescale 1ns / 1ps

module tb;
  import tmr_pkg::*;

  localparam int unsigned NUM_SLOTS   = 8;
  localparam int unsigned NUM_DESTS   = 2;
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 3'd7;

  logic              clk;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [REQ_W-1:0]  req_type_i;
  logic [SLOT_W-1:0] timer_id_i;
  logic [LEN_W-1:0]  length_i;
  logic              periodic_i;
  logic [PID_W-1:0]  source_pid_i;
  logic [PID_W-1:0]  dest_pid_first_i;
  logic [PID_W-1:0]  dest_pid_second_i;
  logic              strobe_o;
  logic [1:0]        kind_o;
  logic [SLOT_W-1:0] slot_o;
  logic [PID_W-1:0]  dest_pid_o;
  logic [PID_W-1:0]  sender_pid_o;
  logic [1:0]        error_o;
  logic              is_active_o;
  logic [LEN_W-1:0]  elapsed_o;
  logic              last_o;

  multi_timer_bank #(
    .NUM_TIMERS(NUM_SLOTS),
    .DEST_SLOTS(NUM_DESTS)
  ) uut (
    .clk_i(clk),
    .rst_ni(rst_ni),
    .start_i(start_i),
    .busy_o(busy_o),
    .req_type_i(req_type_i),
    .timer_id_i(timer_id_i),
    .length_i(length_i),
    .periodic_i(periodic_i),
    .source_pid_i(source_pid_i),
    .dest_pid_first_i(dest_pid_first_i),
    .dest_pid_second_i(dest_pid_second_i),
    .strobe_o(strobe_o),
    .kind_o(kind_o),
    .slot_o(slot_o),
    .dest_pid_o(dest_pid_o),
    .sender_pid_o(sender_pid_o),
    .error_o(error_o),
    .is_active_o(is_active_o),
    .elapsed_o(elapsed_o),
    .last_o(last_o)
  );

  // shadow copy of the bank
  bit               used_q     [NUM_SLOTS];
  bit               active_q   [NUM_SLOTS];
  bit               periodic_q [NUM_SLOTS];
  logic [LEN_W-1:0] length_q   [NUM_SLOTS];
  logic [LEN_W-1:0] count_q    [NUM_SLOTS];
  logic [PID_W-1:0] source_q   [NUM_SLOTS];
  logic [PID_W-1:0] dests_q    [NUM_SLOTS][NUM_DESTS];

  res_t due_results[$];
  int   errors;
  int   idle_pct;
  int   n_cmds, n_replies, n_expiries, n_ticks;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("** multi_timer_bank: FAILED **");
    $finish;
  end

  // expected results of one accepted command, with the shadow state advanced
  task automatic bank_step(input logic [REQ_W-1:0] req, input logic [SLOT_W-1:0] id,
                           input logic [LEN_W-1:0] len, input logic per,
                           input logic [PID_W-1:0] src, input logic [PID_W-1:0] d1,
                           input logic [PID_W-1:0] d2);
    res_t r;
    res_t msg;
    r       = '0;
    r.kind  = KIND_REPLY;
    r.slot  = id;
    r.error = ERR_OK;
    r.last  = 1'b1;
    if (req == REQ_TICK) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (used_q[i] && active_q[i]) begin
          count_q[i] = count_q[i] + 1;
          if (count_q[i] >= length_q[i]) begin
            for (int d = 0; d < NUM_DESTS; d++) begin
              if (dests_q[i][d] != '0) begin
                msg            = '0;
                msg.kind       = KIND_EXPIRY;
                msg.slot       = SLOT_W'(i);
                msg.dest_pid   = dests_q[i][d];
                msg.sender_pid = source_q[i];
                msg.error      = ERR_OK;
                due_results.push_back(msg);
              end
            end
            count_q[i] = '0;
            if (!periodic_q[i]) active_q[i] = 1'b0;
          end
        end
      end
      r.kind = KIND_TICK_DONE;
      r.slot = '0;
    end else if (req == REQ_CREATE) begin
      r.slot  = '0;
      r.error = ERR_FULL;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (!used_q[i] && r.error == ERR_FULL) begin
          used_q[i]     = 1'b1;
          active_q[i]   = 1'b0;
          count_q[i]    = '0;
          length_q[i]   = len;
          periodic_q[i] = per;
          source_q[i]   = src;
          dests_q[i][0] = d1;
          dests_q[i][1] = d2;
          r.slot        = SLOT_W'(i);
          r.error       = ERR_OK;
        end
      end
    end else if (req != REQ_UNKNOWN) begin
      if (int'(id) >= NUM_SLOTS) begin
        r.error = ERR_RANGE;
      end else if (req == REQ_DELETE) begin
        used_q[id]   = 1'b0;
        active_q[id] = 1'b0;
      end else if (!used_q[id]) begin
        r.error = ERR_NOT_CREATED;
      end else begin
        case (req)
          REQ_START: begin
            active_q[id] = 1'b1;
            count_q[id]  = '0;
          end
          REQ_STOP: active_q[id] = 1'b0;
          REQ_SET_LEN: begin
            length_q[id] = len;
            count_q[id]  = '0;
          end
          default: begin
            r.is_active = active_q[id];
            r.elapsed   = count_q[id];
          end
        endcase
      end
    end
    due_results.push_back(r);
  endtask

  // every accepted beat goes through the shadow model
  always @(posedge clk) begin
    if (rst_ni && start_i && busy_o === 1'b0) begin
      n_cmds++;
      bank_step(req_type_i, timer_id_i, length_i, periodic_i, source_pid_i,
                dest_pid_first_i, dest_pid_second_i);
    end
  end

  task automatic check_field(input string name, input logic [LEN_W-1:0] exp_v,
                             input logic [LEN_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    res_t e;
    if (rst_ni && strobe_o === 1'b1) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got kind %0d slot %0d", $time,
                 kind_o, slot_o);
        errors++;
      end else begin
        e = due_results.pop_front();
        check_field("kind", LEN_W'(e.kind), LEN_W'(kind_o));
        check_field("slot", LEN_W'(e.slot), LEN_W'(slot_o));
        check_field("dest_pid", LEN_W'(e.dest_pid), LEN_W'(dest_pid_o));
        check_field("sender_pid", LEN_W'(e.sender_pid), LEN_W'(sender_pid_o));
        check_field("error", LEN_W'(e.error), LEN_W'(error_o));
        check_field("is_active", LEN_W'(e.is_active), LEN_W'(is_active_o));
        check_field("elapsed", e.elapsed, elapsed_o);
        check_field("last", LEN_W'(e.last), LEN_W'(last_o));
        case (e.kind)
          KIND_EXPIRY:    n_expiries++;
          KIND_TICK_DONE: n_ticks++;
          default:        n_replies++;
        endcase
      end
    end
  end

  // one command beat; start stays high on return so a back-to-back beat can follow
  task automatic issue_cmd(input logic [REQ_W-1:0] req, input logic [SLOT_W-1:0] id,
                           input logic [LEN_W-1:0] len, input logic per,
                           input logic [PID_W-1:0] src, input logic [PID_W-1:0] d1,
                           input logic [PID_W-1:0] d2);
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start_i           <= 1'b1;
    req_type_i        <= req;
    timer_id_i        <= id;
    length_i          <= len;
    periodic_i        <= per;
    source_pid_i      <= src;
    dest_pid_first_i  <= d1;
    dest_pid_second_i <= d2;
    do @(posedge clk); while (busy_o !== 1'b0);
  endtask

  task automatic wait_bank_idle();
    start_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  function automatic logic [PID_W-1:0] pick_pid();
    int r;
    r = $urandom_range(99);
    if (r < 25) return '0;
    if (r < 35) return '1;
    return PID_W'($urandom_range(1, 65535));
  endfunction

  // fill all slots with extreme settings, then one create too many
  task automatic test_fill_bank();
    issue_cmd(REQ_CREATE, 3'd0, 32'd0, 1'b1, 16'hFFFF, 16'hFFFF, 16'h0001);
    issue_cmd(REQ_CREATE, 3'd0, 32'd1, 1'b0, 16'h0000, 16'h0000, 16'h0000);
    issue_cmd(REQ_CREATE, 3'd7, 32'd2, 1'b1, 16'h1234, 16'h0000, 16'hFFFF);
    issue_cmd(REQ_CREATE, 3'd0, 32'hFFFF_FFFF, 1'b0, 16'h8000, 16'h0001, 16'h8000);
    for (int k = 0; k < 4; k++)
      issue_cmd(REQ_CREATE, SLOT_W'(k), 32'h5555_5555 << k, k[0], 16'hA5A5 ^ PID_W'(k),
                16'h5A5A, 16'h00FF);
    issue_cmd(REQ_CREATE, 3'd0, 32'd7, 1'b1, 16'h0042, 16'h0043, 16'h0044);
  endtask

  // delete a slot twice, then hit the free slot with query, start, stop and set length, then an unknown request
  task automatic test_free_slot_errors();
    issue_cmd(REQ_DELETE, 3'd5, '0, 1'b0, '0, '0, '0);
    issue_cmd(REQ_DELETE, 3'd5, '0, 1'b0, '0, '0, '0);
    issue_cmd(REQ_QUERY, 3'd5, '0, 1'b0, '0, '0, '0);
    issue_cmd(REQ_START, 3'd5, '0, 1'b0, '0, '0, '0);
    issue_cmd(REQ_STOP, 3'd5, '0, 1'b0, '0, '0, '0);
    issue_cmd(REQ_SET_LEN, 3'd5, 32'hFFFF_FFFF, 1'b1, '1, '1, '1);
    issue_cmd(REQ_UNKNOWN, 3'd3, 32'hFFFF_FFFF, 1'b1, '1, '1, '1);
  endtask

  // zero length, one-shot without destinations, periodic with one destination
  task automatic test_expiry_paths();
    issue_cmd(REQ_START, 3'd0, '0, 1'b0, '0, '0, '0);
    issue_cmd(REQ_START, 3'd1, '0, 1'b0, '0, '0, '0);
    issue_cmd(REQ_START, 3'd2, '0, 1'b0, '0, '0, '0);
    issue_cmd(REQ_START, 3'd3, '0, 1'b0, '0, '0, '0);
    issue_cmd(REQ_TICK, 3'd0, '0, 1'b0, '0, '0, '0);
    issue_cmd(REQ_TICK, 3'd0, '0, 1'b0, '0, '0, '0);
    issue_cmd(REQ_SET_LEN, 3'd2, 32'd3, 1'b0, '0, '0, '0);
    issue_cmd(REQ_QUERY, 3'd3, '0, 1'b0, '0, '0, '0);
    issue_cmd(REQ_STOP, 3'd0, '0, 1'b0, '0, '0, '0);
    issue_cmd(REQ_TICK, 3'd0, '0, 1'b0, '0, '0, '0);
  endtask

  // mostly sensible traffic on created slots, with ticks in between and some noise
  task automatic test_random_traffic(input int n);
    int               r;
    int               pick;
    logic [REQ_W-1:0] req;
    logic [SLOT_W-1:0] id;
    logic [LEN_W-1:0] len;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      req = r < 30 ? REQ_TICK : r < 45 ? REQ_CREATE : r < 60 ? REQ_START :
            r < 70 ? REQ_QUERY : r < 78 ? REQ_STOP : r < 86 ? REQ_SET_LEN :
            r < 96 ? REQ_DELETE : REQ_UNKNOWN;
      id = SLOT_W'($urandom_range(NUM_SLOTS - 1));
      // aim most slot commands at a live timer
      if (req != REQ_DELETE && $urandom_range(99) < 80) begin
        pick = $urandom_range(NUM_SLOTS - 1);
        for (int s = 0; s < NUM_SLOTS; s++)
          if (used_q[(pick + s) % NUM_SLOTS] && !used_q[id])
            id = SLOT_W'((pick + s) % NUM_SLOTS);
      end
      case ($urandom_range(9))
        7:       len = $urandom;
        8:       len = '1;
        9:       len = '0;
        default: len = LEN_W'($urandom_range(0, 5));
      endcase
      issue_cmd(req, id, len, 1'($urandom_range(1)), pick_pid(), pick_pid(), pick_pid());
    end
    wait_bank_idle();
  endtask

  initial begin
    errors            = 0;
    idle_pct          = 23;
    rst_ni            = 1'b0;
    start_i           = 1'b0;
    req_type_i        = '0;
    timer_id_i        = '0;
    length_i          = '0;
    periodic_i        = 1'b0;
    source_pid_i      = '0;
    dest_pid_first_i  = '0;
    dest_pid_second_i = '0;
    repeat (4) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_fill_bank();
    test_free_slot_errors();
    test_expiry_paths();
    wait_bank_idle();

    idle_pct = 23;
    test_random_traffic(42);
    idle_pct = 59;
    test_random_traffic(42);
    idle_pct = 0;
    test_random_traffic(42);

    if (due_results.size() != 0) begin
      $display("%0t: %0d results still expected at the end, got none", $time,
               due_results.size());
      errors++;
    end
    $display("ran %0d commands through the bank with sender gaps of 23, 59 and 0 percent",
             n_cmds);
    $display("checked %0d replies, %0d expiry messages and %0d tick ends", n_replies,
             n_expiries, n_ticks);
    if (errors == 0) begin
      $display("** multi_timer_bank: PASSED **");
    end else begin
      $display("** multi_timer_bank: FAILED **");
    end
    $finish;
  end

endmodule
